>>> src/tcce_pkg.sv
// Package: shared types and codes for the text console character engine.
package tcce_pkg;

  typedef enum logic [1:0] {
    MODE_WRITE      = 2'd0,
    MODE_READ       = 2'd1,
    MODE_SET_CURSOR = 2'd2,
    MODE_CLEAR      = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_DECODE,
    ST_READ,
    ST_TAB,
    ST_BLANK,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_HT       = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] READ_CURSOR = 8'hFF;

  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [7:0] target_x;
    logic [7:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_invalid;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_status_t;

endpackage

>>> src/text_console_character_engine_top.sv
// Top level: request/response channels, APB register and result register.
//
//  channel   signals                                    role
//  req       req_valid, req_ready, req                  one command transaction
//  rsp       rsp_valid, rsp_ready, rsp                  one result per command
//  apb       psel, penable, pwrite, paddr, pwdata, ...  text_attribute register
//
// A printable character in the last cell of the bottom row, and LF or VT
// on the bottom row, scroll the screen; HT leaves the cursor where it is
// when the tab stop lies past the line. The single write port of the
// screen memory writes one cell per cycle.
// After reset the screen memory is swept to spaces, and req_ready stays
// low meanwhile; APB writes are taken at all times.
// A waiting response sits in the output register while the next command
// is already accepted and worked on.
module text_console_character_engine_top #(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tcce_pkg::in_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output tcce_pkg::out_item_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tcce_pkg::*;

  logic [7:0]  attr;
  eng_status_t status;
  out_item_t   res;
  logic        res_ready;

  // APB: one register, word index in paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'h0, attr} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_TEXT_ATTR) begin
      attr <= pwdata[7:0];
    end
  end

  // engine takes a command only when its sequencer is idle
  assign req_ready = status.idle;
  // output register frees the engine once the result is handed over
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (status.res_valid && res_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  tcce_engine #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (req_valid && req_ready),
    .item      (req),
    .attr      (attr),
    .res_ready (res_ready),
    .status    (status),
    .res       (res)
  );

endmodule

>>> src/tcce_engine.sv
// Screen store, cursor state and the sequencer that walks it.
module tcce_engine #(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tcce_pkg::in_item_t item,
  input  logic [7:0]         attr,
  input  logic               res_ready,
  output tcce_pkg::eng_status_t status,
  output tcce_pkg::out_item_t  res
);
  import tcce_pkg::*;

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(COLS + 1);
  localparam int TW_W  = $clog2(TAB_WIDTH + 1);

  state_e state, state_next;

  in_item_t          item_q;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [RW-1:0]     top_row;
  logic [RW-1:0]     prow;
  logic [CW-1:0]     col_q;
  logic              bad_q;
  logic              scroll_pend;
  logic [RW-1:0]     scroll_row;
  logic [AW-1:0]     bl_addr;
  logic [CNTW-1:0]   bl_cnt;
  logic [CW-1:0]     sc;
  logic [TW_W-1:0]   ph;
  logic [7:0]        res_char;
  logic              res_inv;

  // memory
  logic [15:0]   mem [DEPTH];
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [15:0]   wdata;
  logic [15:0]   rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // decode helpers
  logic [7:0]    code;
  logic          is_cur;
  logic [7:0]    rd_x8;
  logic [7:0]    rd_y8;
  logic          rd_bad;
  logic [RW-1:0] row_pick;
  logic [CW-1:0] col_pick;
  logic [RW:0]   psum;
  logic [AW-1:0] base;
  logic          at_bottom;
  logic          at_right;
  logic [TW_W-1:0] tab_t;
  logic [8:0]    tab_stop;
  logic          tab_ok;
  logic          printable;

  assign code      = item_q.char_code;
  assign is_cur    = item_q.target_x == READ_CURSOR;
  assign rd_x8     = is_cur ? 8'(cur_col) : item_q.target_x;
  assign rd_y8     = is_cur ? 8'(cur_row) : item_q.target_y;
  assign rd_bad    = ({1'b0, rd_x8} >= 9'(COLS)) || ({1'b0, rd_y8} >= 9'(ROWS));
  assign row_pick  = (item_q.mode == MODE_READ) ? rd_y8[RW-1:0] : cur_row;
  assign col_pick  = (item_q.mode == MODE_READ) ? rd_x8[CW-1:0] :
                     (code == CH_BS) ? cur_col - CW'(1) : cur_col;
  assign psum      = (RW+1)'(top_row) + (RW+1)'(row_pick);
  assign base      = AW'(prow) * AW'(COLS) + AW'(col_q);
  assign at_bottom = cur_row == RW'(ROWS - 1);
  assign at_right  = cur_col == CW'(COLS - 1);
  assign tab_t     = TW_W'(TAB_WIDTH) - ph;
  assign tab_stop  = 9'(cur_col) + 9'(tab_t);
  assign tab_ok    = tab_stop < 9'(COLS);
  assign printable = code >= CH_SPACE;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (bl_addr == AW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (item_q.mode)
          MODE_READ:       state_next = bad_q ? ST_DONE : ST_READ;
          MODE_SET_CURSOR: state_next = ST_DONE;
          MODE_CLEAR:      state_next = ST_CLEAR;
          default: begin
            if (code == CH_BS) state_next = (cur_col != '0) ? ST_BLANK : ST_DONE;
            else if (code == CH_HT) state_next = ST_TAB;
            else if (code == CH_LF || code == CH_VT) state_next = ST_BLANK;
            else if (printable && at_right && at_bottom) state_next = ST_SCROLL;
            else state_next = ST_DONE;
          end
        endcase
      end
      ST_READ:   state_next = ST_DONE;
      ST_TAB:    if (sc == cur_col) state_next = tab_ok ? ST_BLANK : ST_DONE;
      ST_BLANK:  if (bl_cnt == CNTW'(1)) state_next = scroll_pend ? ST_SCROLL : ST_DONE;
      ST_SCROLL: state_next = ST_BLANK;
      ST_CLEAR:  if (bl_addr == AW'(DEPTH - 1)) state_next = ST_DONE;
      ST_DONE:   if (res_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory port and status
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = bl_addr;
    raddr = base;
    wdata = {attr, CH_SPACE};
    unique case (state)
      ST_INIT: begin
        we    = 1'b1;
        wdata = {8'h00, CH_SPACE};
      end
      ST_DECODE: begin
        if (item_q.mode == MODE_READ) begin
          re = !bad_q;
        end else if (item_q.mode == MODE_WRITE && printable) begin
          we    = 1'b1;
          waddr = base;
          wdata = {attr, code};
        end
      end
      ST_BLANK, ST_CLEAR: we = 1'b1;
      default: ;
    endcase
  end

  assign status.idle      = state == ST_IDLE;
  assign status.res_valid = state == ST_DONE;
  assign res.read_char    = res_char;
  assign res.read_invalid = res_inv;
  assign res.cursor_col   = 7'(cur_col);
  assign res.cursor_row   = 5'(cur_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cur_col     <= '0;
      cur_row     <= '0;
      top_row     <= '0;
      bl_addr     <= '0;
      scroll_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          bl_addr <= (bl_addr == AW'(DEPTH - 1)) ? '0 : bl_addr + AW'(1);
        end
        ST_IDLE: if (start) item_q <= item;
        ST_PREP: begin
          prow     <= (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : psum[RW-1:0];
          col_q    <= col_pick;
          bad_q    <= rd_bad;
          res_char <= '0;
          res_inv  <= 1'b0;
        end
        ST_DECODE: begin
          unique case (item_q.mode)
            MODE_READ: res_inv <= bad_q;
            MODE_SET_CURSOR: begin
              cur_col <= ({1'b0, item_q.target_x} >= 9'(COLS)) ?
                         CW'(COLS - 1) : item_q.target_x[CW-1:0];
              cur_row <= ({1'b0, item_q.target_y} >= 9'(ROWS)) ?
                         RW'(ROWS - 1) : item_q.target_y[RW-1:0];
            end
            MODE_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
              top_row <= '0;
              bl_addr <= '0;
            end
            default: begin
              scroll_pend <= 1'b0;
              bl_addr     <= base;
              sc          <= '0;
              ph          <= '0;
              if (code == CH_BS) begin
                bl_cnt <= CNTW'(1);
                if (cur_col != '0) cur_col <= cur_col - CW'(1);
              end else if (code == CH_LF || code == CH_VT || (printable && at_right)) begin
                bl_cnt <= (code == CH_LF) ? CNTW'(COLS) - CNTW'(cur_col) : CNTW'(COLS);
                if (code != CH_VT) cur_col <= '0;
                // next row, scrolling at the bottom
                if (at_bottom) begin
                  scroll_pend <= 1'b1;
                  scroll_row  <= top_row;
                  top_row     <= (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
                end else begin
                  cur_row <= cur_row + RW'(1);
                end
              end else if (printable) begin
                cur_col <= cur_col + CW'(1);
              end
            end
          endcase
        end
        ST_READ: res_char <= rdata[7:0];
        ST_TAB: begin
          if (sc == cur_col) begin
            if (tab_ok) begin
              bl_addr <= base;
              bl_cnt  <= CNTW'(tab_t);
              cur_col <= tab_stop[CW-1:0];
            end
          end else begin
            sc <= sc + CW'(1);
            ph <= (ph == TW_W'(TAB_WIDTH - 1)) ? '0 : ph + TW_W'(1);
          end
        end
        ST_SCROLL: begin
          bl_addr     <= AW'(scroll_row) * AW'(COLS);
          bl_cnt      <= CNTW'(COLS);
          scroll_pend <= 1'b0;
        end
        ST_BLANK: begin
          bl_addr <= (bl_addr == AW'(DEPTH - 1)) ? '0 : bl_addr + AW'(1);
          bl_cnt  <= bl_cnt - CNTW'(1);
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(cur_col) < (CW+1)'(COLS)) && ((RW+1)'(cur_row) < (RW+1)'(ROWS)) &&
    ((RW+1)'(top_row) < (RW+1)'(ROWS)))
    else $error("cursor or top row out of range");
  a_blank_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BLANK) |-> (bl_cnt != '0))
    else $error("blank run with zero count");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_inv) |-> (res_char == 8'h00))
    else $error("invalid read returned a character");
  a_init_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INIT && bl_addr == AW'(DEPTH - 1)) |=> (state == ST_IDLE))
    else $error("clearing pass did not end");
`endif

endmodule

>>> sim/tcce_checker.sv
// Checker: screen predictor and response scoreboard for the text console engine.
`timescale 1ns / 1ps
module tcce_checker #(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  tcce_pkg::in_item_t  req,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  tcce_pkg::out_item_t rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output int                  fail_count,
  output int                  pending
);
  import tcce_pkg::*;

  logic [15:0] cells [COLS*ROWS];
  int top, ccol, crow;
  logic [7:0] attr;
  out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic int idx(int row, int col);
    return ((top + row) % ROWS) * COLS + (col % COLS);
  endfunction

  function automatic void blank(int row, int col);
    cells[idx(row, col)] = {attr, CH_SPACE};
  endfunction

  function automatic void next_row();
    crow++;
    if (crow >= ROWS) begin
      top = (top + 1) % ROWS;
      for (int c = 0; c < COLS; c++) blank(ROWS - 1, c);
      crow = ROWS - 1;
    end
  endfunction

  function automatic void write_char(logic [7:0] ch);
    int t;
    if (ch == CH_BS) begin
      if (ccol > 0) begin
        blank(crow, ccol - 1);
        ccol--;
      end
    end else if (ch == CH_HT) begin
      t = TAB_WIDTH - (ccol % TAB_WIDTH);
      if (ccol + t < COLS) begin
        for (int i = 0; i < t; i++) blank(crow, ccol + i);
        ccol += t;
      end
    end else if (ch == CH_LF) begin
      for (int c = ccol; c < COLS; c++) blank(crow, c);
      ccol = 0;
      next_row();
    end else if (ch == CH_VT) begin
      next_row();
      // old cursor cell is one row up now, fill runs into the next row
      for (int n = 0; n < COLS; n++)
        if (ccol + n < COLS) blank(crow - 1, ccol + n);
        else blank(crow, ccol + n - COLS);
    end else if (ch >= CH_SPACE) begin
      cells[idx(crow, ccol)] = {attr, ch};
      ccol++;
      if (ccol >= COLS) begin
        ccol = 0;
        next_row();
      end
    end
  endfunction

  function automatic out_item_t predict_response(in_item_t it);
    out_item_t r;
    int x, y;
    r = '0;
    case (mode_e'(it.mode))
      MODE_WRITE: write_char(it.char_code);
      MODE_READ: begin
        x = it.target_x;
        y = it.target_y;
        if (it.target_x == READ_CURSOR) begin
          x = ccol;
          y = crow;
        end
        if (x >= COLS || y >= ROWS) r.read_invalid = 1'b1;
        else r.read_char = cells[idx(y, x)][7:0];
      end
      MODE_SET_CURSOR: begin
        ccol = (it.target_x >= COLS) ? COLS - 1 : it.target_x;
        crow = (it.target_y >= ROWS) ? ROWS - 1 : it.target_y;
      end
      default: begin
        for (int i = 0; i < COLS*ROWS; i++) cells[i] = {attr, CH_SPACE};
        top = 0;
        ccol = 0;
        crow = 0;
      end
    endcase
    r.cursor_col = 7'(ccol);
    r.cursor_row = 5'(crow);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      for (int i = 0; i < COLS*ROWS; i++) cells[i] = {8'h00, CH_SPACE};
      top = 0;
      ccol = 0;
      crow = 0;
      attr = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTR)
        attr = pwdata[7:0];
      if (req_valid && req_ready) expected_q.push_back(predict_response(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected response transaction %h", rsp);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.read_char !== e.read_char) begin
            $error("read_char exp %h got %h", e.read_char, rsp.read_char);
            fail_count++;
          end
          if (rsp.read_invalid !== e.read_invalid) begin
            $error("read_invalid exp %b got %b", e.read_invalid, rsp.read_invalid);
            fail_count++;
          end
          if (rsp.cursor_col !== e.cursor_col) begin
            $error("cursor_col exp %0d got %0d", e.cursor_col, rsp.cursor_col);
            fail_count++;
          end
          if (rsp.cursor_row !== e.cursor_row) begin
            $error("cursor_row exp %0d got %0d", e.cursor_row, rsp.cursor_row);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_text_console_character_engine_top.sv
// Testbench top: stimulus, APB attribute writes and the final verdict.
`timescale 1ns / 1ps
module tb_text_console_character_engine_top;
  import tcce_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_item_t rsp;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending;

  // idle percentages for sender and receiver, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_character_engine_top dut (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tcce_checker chk (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  // receiver: random stalls, redrawn each cycle
  always @(posedge clk)
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

  // one transaction; valid stays high until accepted, idle gaps before it
  task automatic send_cmd(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    req_valid <= 1'b1;
    req <= it;
    // ready only moves at rising edges; look at it mid-cycle
    @(negedge clk);
    while (!req_ready) @(negedge clk);
    @(posedge clk);
    req_valid <= 1'b0;
    sent++;
    @(posedge clk);
  endtask

  task automatic cmd(mode_e m, logic [7:0] ch, logic [7:0] x, logic [7:0] y);
    in_item_t it;
    it.mode = m;
    it.char_code = ch;
    it.target_x = x;
    it.target_y = y;
    send_cmd(it);
  endtask

  // drain all results, then let the bench sit idle before touching config
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] a);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {16'h0, 8'($urandom_range(255)), a};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random command: writes, reads, cursor moves and a rare clear; writes mix printable text and control codes
  task automatic random_cmd();
    int r;
    logic [7:0] ch, x, y;
    r = $urandom_range(99);
    x = 8'($urandom_range(255));
    y = 8'($urandom_range(255));
    ch = 8'($urandom_range(255));
    if (r < 55) begin
      case ($urandom_range(9))
        0: ch = CH_BS;
        1: ch = CH_HT;
        2: ch = CH_LF;
        3: ch = CH_VT;
        4: ch = 8'($urandom_range(31));
        default: ch = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      cmd(MODE_WRITE, ch, x, y);
    end else if (r < 85) begin
      // reads: mostly on screen, some cursor reads, some off screen
      case ($urandom_range(3))
        0: x = READ_CURSOR;
        1: ;
        default: begin
          x = 8'($urandom_range(COLS - 1));
          y = 8'($urandom_range(ROWS - 1));
        end
      endcase
      cmd(MODE_READ, ch, x, y);
    end else if (r < 99) begin
      if ($urandom_range(1)) begin
        x = 8'($urandom_range(COLS - 1));
        y = 8'($urandom_range(ROWS - 1));
      end
      cmd(MODE_SET_CURSOR, ch, x, y);
    end else begin
      cmd(MODE_CLEAR, ch, x, y);
    end
  endtask

  initial begin
    int phase_pct [4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{18, 18}};
    logic [7:0] attrs [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_attr(8'h1F);

    // directed: each control code, ignored codes, field extremes, reads
    cmd(MODE_WRITE, 8'h41, 8'h00, 8'h00);
    cmd(MODE_WRITE, 8'hFF, 8'hFF, 8'hFF);
    cmd(MODE_WRITE, 8'h7F, 8'h00, 8'h00);
    cmd(MODE_WRITE, 8'h00, 8'h00, 8'h00);
    cmd(MODE_WRITE, 8'h1F, 8'h00, 8'h00);
    cmd(MODE_WRITE, CH_BS, 8'h00, 8'h00);
    cmd(MODE_WRITE, CH_HT, 8'h00, 8'h00);
    cmd(MODE_READ, 8'h00, 8'h00, 8'h00);
    cmd(MODE_READ, 8'h00, READ_CURSOR, 8'h00);
    cmd(MODE_READ, 8'h00, 8'd80, 8'd0);
    cmd(MODE_READ, 8'h00, 8'd0, 8'd25);
    cmd(MODE_SET_CURSOR, 8'h00, 8'd0, 8'd0);
    cmd(MODE_WRITE, CH_BS, 8'h00, 8'h00);
    cmd(MODE_SET_CURSOR, 8'h00, 8'hFE, 8'hFF);
    cmd(MODE_WRITE, CH_HT, 8'h00, 8'h00);
    cmd(MODE_WRITE, 8'h42, 8'h00, 8'h00);
    cmd(MODE_SET_CURSOR, 8'h00, 8'd40, 8'd24);
    cmd(MODE_WRITE, CH_LF, 8'h00, 8'h00);
    cmd(MODE_WRITE, CH_VT, 8'h00, 8'h00);
    cmd(MODE_READ, 8'h00, 8'd79, 8'd24);
    cmd(MODE_READ, 8'h00, 8'd40, 8'd23);
    cmd(MODE_CLEAR, 8'hAA, 8'h55, 8'hAA);
    cmd(MODE_READ, 8'h00, 8'd0, 8'd0);
    // sender holds off until every result is back
    drain();

    for (int p = 0; p < 4; p++) begin
      write_attr(attrs[p]);
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      repeat (470) random_cmd();
      drain();
    end

    recv_stall_pct = 0;
    $display("Covered %0d commands over four idle/stall phases and four text attributes.",
             sent);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // timeout: worst-case clears and scrolls with stalls, several times over
  initial begin
    #80ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> text_console_character_engine_top.f
src/tcce_pkg.sv
src/tcce_engine.sv
src/text_console_character_engine_top.sv
sim/tcce_checker.sv
sim/tb_text_console_character_engine_top.sv
